// ===== rtl/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants of the keyed record table: table depth, index
// widths, command and status codes, record layout and the memory request.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = IDX_W + 1;
  localparam int MEM_DEPTH   = 2 ** ADDR_W;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // one stored record
  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] qty;
    logic signed [DATA_W-1:0] price;
  } rec_t;

  // one access to the record memory: one write port, one read port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    rec_t              wdata;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

endpackage

// ===== rtl/krt_cmd_if.sv =====
// ----------------------------------------------------------------------------
// krt_cmd_if
// Command channel: one word holds an operation code, a key, a quantity and
// a price.
// ----------------------------------------------------------------------------
interface krt_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic        [krt_pkg::CMD_W-1:0]     cmd;
  logic signed [krt_pkg::DATA_W-1:0]    part_key;
  logic signed [krt_pkg::DATA_W-1:0]    quantity_in;
  logic signed [krt_pkg::DATA_W-1:0]    price_in;

  modport source (output valid, cmd, part_key, quantity_in, price_in, input ready);
  modport sink   (input valid, cmd, part_key, quantity_in, price_in, output ready);
endinterface

// ===== rtl/krt_res_if.sv =====
// ----------------------------------------------------------------------------
// krt_res_if
// Result channel: one word holds a status, a record and the last marker.
// ----------------------------------------------------------------------------
interface krt_res_if;
  logic                                 valid;
  logic                                 ready;
  logic        [krt_pkg::STATUS_W-1:0]  status;
  logic signed [krt_pkg::DATA_W-1:0]    key_out;
  logic signed [krt_pkg::DATA_W-1:0]    quantity_out;
  logic signed [krt_pkg::DATA_W-1:0]    price_out;
  logic                                 last;

  modport source (output valid, status, key_out, quantity_out, price_out, last,
                  input ready);
  modport sink   (input valid, status, key_out, quantity_out, price_out, last,
                  output ready);
endinterface

// ===== rtl/krt_store.sv =====
// ----------------------------------------------------------------------------
// krt_store
// Record memory with two banks of TABLE_DEPTH entries. One write and one
// registered read per cycle; contents are undefined until written.
// ----------------------------------------------------------------------------
module krt_store (
  input  logic                  clk_i,
  input  krt_pkg::store_req_t   req_i,
  output krt_pkg::rec_t         rdata_o
);

  krt_pkg::rec_t mem [krt_pkg::MEM_DEPTH];
  krt_pkg::rec_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/krt_ctrl.sv =====
// ----------------------------------------------------------------------------
// krt_ctrl
// Command sequencer: walks the record memory for key lookups, appends and
// updates records, and runs the selection passes of a sorted dump, copying
// the sorted records into the spare bank. Holds the output word register.
// ----------------------------------------------------------------------------
module krt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  krt_cmd_if.sink               cmd_i,
  krt_res_if.source             res_o,
  output krt_pkg::store_req_t   req_o,
  input  krt_pkg::rec_t         rdata_i
);

  localparam int IDX_W  = krt_pkg::IDX_W;
  localparam int CNT_W  = krt_pkg::CNT_W;
  localparam int DATA_W = krt_pkg::DATA_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_DSCAN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  krt_pkg::cmd_e            cmd_q, cmd_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic signed [DATA_W-1:0] qty_q, qty_d;
  logic signed [DATA_W-1:0] price_q, price_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     bank_q, bank_d;
  logic [CNT_W-1:0]         iss_q, iss_d;
  logic                     pend_q, pend_d;
  logic [IDX_W-1:0]         pidx_q, pidx_d;
  krt_pkg::rec_t            best_q, best_d;
  logic [IDX_W-1:0]         best_pos_q, best_pos_d;
  logic                     best_vld_q, best_vld_d;
  logic signed [DATA_W-1:0] lp_q, lp_d;
  logic [IDX_W-1:0]         lpos_q, lpos_d;
  logic                     have_prev_q, have_prev_d;
  logic [IDX_W-1:0]         out_j_q, out_j_d;
  krt_pkg::rec_t            res_q, res_d;
  krt_pkg::status_e         res_st_q, res_st_d;
  logic                     res_last_q, res_last_d;

  logic                     out_vld_q;
  krt_pkg::rec_t            out_rec_q;
  krt_pkg::status_e         out_st_q;
  logic                     out_last_q;

  logic                     iss_more;
  logic                     scan_done;
  logic                     key_hit;
  logic                     slot_free;
  logic                     load;
  logic                     cand_ok;
  logic                     cand_better;
  krt_pkg::rec_t            upd_rec;
  krt_pkg::rec_t            new_rec;
  krt_pkg::rec_t            miss_rec;
  logic [CNT_W-1:0]         out_j_next;

  // scan pipeline status
  assign iss_more   = (iss_q < cnt_q);
  assign scan_done  = !pend_q && !iss_more;
  assign key_hit    = pend_q && (rdata_i.key == key_q);
  assign slot_free  = !out_vld_q || res_o.ready;
  assign out_j_next = CNT_W'({1'b0, out_j_q}) + CNT_W'(1);

  // dump candidate: strictly after the last emitted (price, position)
  assign cand_ok = !have_prev_q
                || ($signed(rdata_i.price) > lp_q)
                || (($signed(rdata_i.price) == lp_q) && (pidx_q > lpos_q));
  // earlier position wins ties, scan runs in ascending position
  assign cand_better = !best_vld_q || ($signed(rdata_i.price) < $signed(best_q.price));

  // record images used on a lookup result
  always_comb begin
    upd_rec       = rdata_i;
    upd_rec.qty   = rdata_i.qty + qty_q;
    new_rec.key   = key_q;
    new_rec.qty   = qty_q;
    new_rec.price = price_q;
    miss_rec.key   = key_q;
    miss_rec.qty   = '0;
    miss_rec.price = '0;
  end

  assign cmd_i.ready = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    qty_d       = qty_q;
    price_d     = price_q;
    cnt_d       = cnt_q;
    bank_d      = bank_q;
    iss_d       = iss_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    best_d      = best_q;
    best_pos_d  = best_pos_q;
    best_vld_d  = best_vld_q;
    lp_d        = lp_q;
    lpos_d      = lpos_q;
    have_prev_d = have_prev_q;
    out_j_d     = out_j_q;
    res_d       = res_q;
    res_st_d    = res_st_q;
    res_last_d  = res_last_q;
    load        = 1'b0;
    req_o.we    = 1'b0;
    req_o.waddr = '0;
    req_o.wdata = new_rec;
    req_o.raddr = {bank_q, iss_q[IDX_W-1:0]};

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d       = krt_pkg::cmd_e'(cmd_i.cmd);
          key_d       = cmd_i.part_key;
          qty_d       = cmd_i.quantity_in;
          price_d     = cmd_i.price_in;
          iss_d       = '0;
          pend_d      = 1'b0;
          best_vld_d  = 1'b0;
          have_prev_d = 1'b0;
          out_j_d     = '0;
          res_last_d  = 1'b1;
          if ((krt_pkg::cmd_e'(cmd_i.cmd) == krt_pkg::CMD_INSERT)
              && (cnt_q == CNT_W'(krt_pkg::TABLE_DEPTH))) begin
            res_d.key   = cmd_i.part_key;
            res_d.qty   = '0;
            res_d.price = '0;
            res_st_d    = krt_pkg::ST_FULL;
            state_d     = S_EMIT;
          end else if (krt_pkg::cmd_e'(cmd_i.cmd) == krt_pkg::CMD_DUMP) begin
            if (cnt_q == '0) begin
              res_d    = '0;
              res_st_d = krt_pkg::ST_EMPTY;
              state_d  = S_EMIT;
            end else begin
              state_d = S_DSCAN;
            end
          end else begin
            state_d = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        // issue the next read
        if (iss_more) begin
          iss_d  = iss_q + CNT_W'(1);
          pend_d = 1'b1;
          pidx_d = iss_q[IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        // check the returned entry
        if (key_hit) begin
          res_st_d = krt_pkg::ST_OK;
          state_d  = S_EMIT;
          case (cmd_q)
            krt_pkg::CMD_INSERT: begin
              res_d    = miss_rec;
              res_st_d = krt_pkg::ST_EXISTS;
            end
            krt_pkg::CMD_UPDATE: begin
              req_o.we    = 1'b1;
              req_o.waddr = {bank_q, pidx_q};
              req_o.wdata = upd_rec;
              res_d       = upd_rec;
            end
            default: begin
              res_d = rdata_i;
            end
          endcase
        end else if (scan_done) begin
          state_d = S_EMIT;
          if (cmd_q == krt_pkg::CMD_INSERT) begin
            req_o.we    = 1'b1;
            req_o.waddr = {bank_q, cnt_q[IDX_W-1:0]};
            req_o.wdata = new_rec;
            cnt_d       = cnt_q + CNT_W'(1);
            res_d       = new_rec;
            res_st_d    = krt_pkg::ST_OK;
          end else begin
            res_d    = miss_rec;
            res_st_d = krt_pkg::ST_NOT_FOUND;
          end
        end
      end

      S_DSCAN: begin
        if (iss_more) begin
          iss_d  = iss_q + CNT_W'(1);
          pend_d = 1'b1;
          pidx_d = iss_q[IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        // keep the smallest remaining record
        if (pend_q && cand_ok && cand_better) begin
          best_d     = rdata_i;
          best_pos_d = pidx_q;
          best_vld_d = 1'b1;
        end
        // end of pass: copy into the spare bank and report it
        if (scan_done) begin
          req_o.we    = 1'b1;
          req_o.waddr = {~bank_q, out_j_q};
          req_o.wdata = best_q;
          res_d       = best_q;
          res_st_d    = krt_pkg::ST_OK;
          res_last_d  = (out_j_next == cnt_q);
          lp_d        = best_q.price;
          lpos_d      = best_pos_q;
          have_prev_d = 1'b1;
          state_d     = S_EMIT;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          load = 1'b1;
          if ((cmd_q == krt_pkg::CMD_DUMP) && !res_last_q) begin
            out_j_d    = out_j_q + IDX_W'(1);
            iss_d      = '0;
            pend_d     = 1'b0;
            best_vld_d = 1'b0;
            state_d    = S_DSCAN;
          end else begin
            // the sorted copy becomes the live bank
            if (cmd_q == krt_pkg::CMD_DUMP) begin
              bank_d = ~bank_q;
            end
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      bank_q      <= 1'b0;
      pend_q      <= 1'b0;
      best_vld_q  <= 1'b0;
      have_prev_q <= 1'b0;
      res_last_q  <= 1'b1;
      cmd_q       <= krt_pkg::CMD_SEARCH;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bank_q      <= bank_d;
      pend_q      <= pend_d;
      best_vld_q  <= best_vld_d;
      have_prev_q <= have_prev_d;
      res_last_q  <= res_last_d;
      cmd_q       <= cmd_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    qty_q      <= qty_d;
    price_q    <= price_d;
    iss_q      <= iss_d;
    pidx_q     <= pidx_d;
    best_q     <= best_d;
    best_pos_q <= best_pos_d;
    lp_q       <= lp_d;
    lpos_q     <= lpos_d;
    out_j_q    <= out_j_d;
    res_q      <= res_d;
    res_st_q   <= res_st_d;
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_rec_q  <= res_q;
      out_st_q   <= res_st_q;
      out_last_q <= res_last_q;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.status       = out_st_q;
  assign res_o.key_out      = out_rec_q.key;
  assign res_o.quantity_out = out_rec_q.qty;
  assign res_o.price_out    = out_rec_q.price;
  assign res_o.last         = out_last_q;

  // entry count only ever grows by one
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("entry count moved by other than one");

  // entry count stays within the table
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CNT_W'(krt_pkg::TABLE_DEPTH)))
    else $error("entry count beyond table depth");

  // a word is never loaded over one the receiver has not taken
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_vld_q || res_o.ready))
    else $error("output word overwritten");

  // banks swap only when the last word of a dump leaves the sequencer
  a_bank_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> $past(load && res_last_q && (cmd_q == krt_pkg::CMD_DUMP)))
    else $error("bank swapped outside dump end");

  // an accepted command always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> (state_q != S_IDLE))
    else $error("accepted command dropped");

endmodule

// ===== rtl/keyed_record_table.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table
// Table of up to TABLE_DEPTH records (key, quantity, price in cents) with
// insert, search, quantity update and a dump sorted by price.
// ----------------------------------------------------------------------------
// Usage: commands arrive on cmd_i as valid/ready words; one command is taken
// at a time, when the sequencer is idle. Results leave on res_o as
// valid/ready words; last marks the final word of each command.
// Insert, search and update walk the stored entries through the record
// memory, one entry per cycle; the walk stops early when the key matches,
// and an insert into a full table skips it. The result word is then handed
// to the output register, and the next command is taken in the cycle after
// that.
// A dump runs one selection pass over the memory per result; each selected
// record is also copied into the spare memory bank, which becomes the live
// bank afterwards.
// An empty table dumps as one word with the empty status.
// Reset clears the entry count and the sequencer; memory contents are not
// cleared and need no clearing pass. When the receiver stalls, the output
// register holds its word and the sequencer waits before loading the next.
// ----------------------------------------------------------------------------
module keyed_record_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  krt_cmd_if.sink   cmd_i,
  krt_res_if.source res_o
);

  krt_pkg::store_req_t store_req;
  krt_pkg::rec_t       store_rdata;

  // command sequencer and output register
  krt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .res_o   (res_o),
    .req_o   (store_req),
    .rdata_i (store_rdata)
  );

  // record memory
  krt_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

endmodule
